// ----- hdl/esvs_pkg.sv -----
// Shared types, constants and color tables for the expanding shell voxel shader.
package esvs_pkg;

  // Field widths
  localparam int COORD_W   = 3;
  localparam int COLOR_W   = 8;
  localparam int RADIUS_W  = 12;
  localparam int HUE_W     = 9;
  localparam int JUMP_W    = 6;
  localparam int STEP_W    = 8;
  localparam int THICK_W   = 9;
  localparam int LIMIT_W   = 11;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 11;

  // Distance datapath: doubled offsets stay within -7..7
  localparam int OFS_W     = 6;
  localparam int ABS_W     = 4;
  localparam int SQ_W      = 8;
  localparam int SUM_W     = 10;
  localparam int FRAC_W    = 14;
  localparam int RAD_N_W   = SUM_W + FRAC_W;
  localparam int ROOT_W    = RAD_N_W / 2;
  localparam int REM_W     = ROOT_W + 3;
  localparam int HTERM_W   = ROOT_W + 6;

  // Hue arithmetic
  localparam int HUE_FULL   = 360;
  localparam int HUE_SECTOR = 60;
  localparam int HUE_STEP   = 3;
  localparam int HUE_SPAN   = 40;
  localparam int HM_W       = 6;
  localparam int HSV_SAT    = 220;
  localparam int HSV_VAL    = 230;
  localparam int COLOR_MAX  = 255;
  localparam logic [COLOR_W-1:0] HSV_P = COLOR_W'(HSV_VAL * (COLOR_MAX - HSV_SAT) / COLOR_MAX);
  localparam logic [COLOR_W-1:0] HSV_V = COLOR_W'(HSV_VAL);

  // Queue
  localparam int QUEUE_DEPTH = 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OVERRIDE_RED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERRIDE_GREEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERRIDE_BLUE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_STEP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHELL_THICK    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_LIMIT   = 3'd5;

  // Reset values of the registers
  localparam logic [STEP_W-1:0]  RADIUS_STEP_RST = 8'd64;
  localparam logic [THICK_W-1:0] SHELL_THICK_RST = 9'd115;
  localparam logic [LIMIT_W-1:0] RADIUS_LIMIT_RST = 11'd1587;

  // Request kinds
  localparam logic REQ_QUERY   = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  typedef struct packed {
    logic [COLOR_W-1:0] override_red;
    logic [COLOR_W-1:0] override_green;
    logic [COLOR_W-1:0] override_blue;
    logic [STEP_W-1:0]  radius_step;
    logic [THICK_W-1:0] shell_thickness;
    logic [LIMIT_W-1:0] radius_limit;
  } cfg_t;

  // One query word as it travels from front to back
  typedef struct packed {
    logic [SUM_W-1:0]    sq_sum;
    logic [RADIUS_W-1:0] radius;
    logic [HUE_W-1:0]    hue_base;
  } query_t;

  typedef struct packed {
    logic   push;
    query_t item;
  } push_t;

  typedef struct packed {
    logic   valid;
    query_t item;
  } head_t;

  typedef logic [COLOR_W-1:0] tab_t [HUE_SECTOR];

  // q component for each position inside a hue sector
  function automatic tab_t build_q_tab();
    tab_t tab;
    int   f;
    for (int i = 0; i < HUE_SECTOR; i++) begin
      f = i * COLOR_MAX / HUE_SECTOR;
      tab[i] = COLOR_W'(HSV_VAL * (COLOR_MAX - (HSV_SAT * f) / COLOR_MAX) / COLOR_MAX);
    end
    return tab;
  endfunction

  // t component for each position inside a hue sector
  function automatic tab_t build_t_tab();
    tab_t tab;
    int   f;
    for (int i = 0; i < HUE_SECTOR; i++) begin
      f = i * COLOR_MAX / HUE_SECTOR;
      tab[i] = COLOR_W'(HSV_VAL * (COLOR_MAX - (HSV_SAT * (COLOR_MAX - f)) / COLOR_MAX)
                        / COLOR_MAX);
    end
    return tab;
  endfunction

  localparam tab_t Q_TAB = build_q_tab();
  localparam tab_t T_TAB = build_t_tab();

endpackage

// ----- hdl/expanding_shell_voxel_shader.sv -----
// Top level of the expanding shell voxel shader: registers, front end, queue, shading pipeline.
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+----------------------------------------
//   in      | input     | in_valid / in_ready  | req_type, voxel_x/y/z, hue_jump
//   out     | output    | out_valid/out_ready  | red, green, blue, lit
//   cfg     | input     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One request word is taken per cycle while the queue has room; a query's color comes out
// after the 12 root stages and the rounding, shell test and color stages.
// An advance word updates the shell state on acceptance and yields no output word.
// rst is synchronous and clears the shell state, the queue and all valid bits.
// A stalled output holds the whole shading pipeline; the front keeps taking words
// until the four-entry queue fills, then drops in_ready.
module expanding_shell_voxel_shader
  import esvs_pkg::*;
#(
  parameter int CUBE_EDGE = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 req_type,
  input  logic [COORD_W-1:0]   voxel_x,
  input  logic [COORD_W-1:0]   voxel_y,
  input  logic [COORD_W-1:0]   voxel_z,
  input  logic [JUMP_W-1:0]    hue_jump,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [COLOR_W-1:0]   red,
  output logic [COLOR_W-1:0]   green,
  output logic [COLOR_W-1:0]   blue,
  output logic                 lit,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  cfg_t  cfg;
  push_t push_w;
  head_t head_w;
  logic  queue_full;
  logic  pop_w;

  assign cfg_ready = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.override_red    <= '0;
      cfg.override_green  <= '0;
      cfg.override_blue   <= '0;
      cfg.radius_step     <= RADIUS_STEP_RST;
      cfg.shell_thickness <= SHELL_THICK_RST;
      cfg.radius_limit    <= RADIUS_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OVERRIDE_RED:   cfg.override_red    <= cfg_data[COLOR_W-1:0];
        CFG_OVERRIDE_GREEN: cfg.override_green  <= cfg_data[COLOR_W-1:0];
        CFG_OVERRIDE_BLUE:  cfg.override_blue   <= cfg_data[COLOR_W-1:0];
        CFG_RADIUS_STEP:    cfg.radius_step     <= cfg_data[STEP_W-1:0];
        CFG_SHELL_THICK:    cfg.shell_thickness <= cfg_data[THICK_W-1:0];
        CFG_RADIUS_LIMIT:   cfg.radius_limit    <= cfg_data[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  esvs_front #(
    .CUBE_EDGE (CUBE_EDGE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .voxel_x    (voxel_x),
    .voxel_y    (voxel_y),
    .voxel_z    (voxel_z),
    .hue_jump   (hue_jump),
    .cfg        (cfg),
    .queue_full (queue_full),
    .push_out   (push_w)
  );

  esvs_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push_in (push_w),
    .full    (queue_full),
    .pop     (pop_w),
    .head    (head_w)
  );

  esvs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head_w),
    .pop       (pop_w),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .lit       (lit)
  );

endmodule

// ----- hdl/esvs_front.sv -----
// Front end: accepts request words, steps the shell state and queues voxel queries.
module esvs_front
  import esvs_pkg::*;
#(
  parameter int CUBE_EDGE = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               req_type,
  input  logic [COORD_W-1:0] voxel_x,
  input  logic [COORD_W-1:0] voxel_y,
  input  logic [COORD_W-1:0] voxel_z,
  input  logic [JUMP_W-1:0]  hue_jump,
  input  cfg_t               cfg,
  input  logic               queue_full,
  output push_t              push_out
);

  localparam logic signed [OFS_W-1:0] CENTER2 = OFS_W'(CUBE_EDGE - 1);
  localparam logic [HUE_W:0] HUE_FULL_V = (HUE_W+1)'(HUE_FULL);

  logic [RADIUS_W-1:0] shell_radius;
  logic [HUE_W-1:0]    hue_base;
  logic [RADIUS_W-1:0] shell_radius_next;
  logic [HUE_W-1:0]    hue_base_next;
  logic                accept;

  logic [RADIUS_W-1:0] rad_sum;
  logic [HUE_W:0]      hue_step;
  logic [HUE_W-1:0]    hue_stepped;
  logic [HUE_W:0]      hue_jumped;

  logic [ABS_W-1:0] ax, ay, az;
  logic [SUM_W-1:0] sq_sum;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  // Absolute doubled offset of one coordinate from the cube center
  function automatic logic [ABS_W-1:0] abs_offset(input logic [COORD_W-1:0] c);
    logic signed [OFS_W-1:0] d;
    d = $signed({{(OFS_W-COORD_W-1){1'b0}}, c, 1'b0}) - CENTER2;
    return d[OFS_W-1] ? ABS_W'(-d) : ABS_W'(d);
  endfunction

  // Square sum of the doubled offsets
  always_comb begin
    ax = abs_offset(voxel_x);
    ay = abs_offset(voxel_y);
    az = abs_offset(voxel_z);
    sq_sum = SUM_W'(SQ_W'(ax * ax)) + SUM_W'(SQ_W'(ay * ay)) + SUM_W'(SQ_W'(az * az));
  end

  // Advance the shell by one frame
  always_comb begin
    rad_sum  = shell_radius + RADIUS_W'(cfg.radius_step);
    hue_step = {1'b0, hue_base} + (HUE_W+1)'(HUE_STEP);
    hue_stepped = (hue_step >= HUE_FULL_V) ? HUE_W'(hue_step - HUE_FULL_V) : HUE_W'(hue_step);
    hue_jumped = {1'b0, hue_stepped} + (HUE_W+1)'(hue_jump);
    shell_radius_next = shell_radius;
    hue_base_next     = hue_base;
    if (accept && req_type == REQ_ADVANCE) begin
      if (rad_sum > RADIUS_W'(cfg.radius_limit)) begin
        shell_radius_next = '0;
        hue_base_next = (hue_jumped >= HUE_FULL_V) ? HUE_W'(hue_jumped - HUE_FULL_V)
                                                   : HUE_W'(hue_jumped);
      end else begin
        shell_radius_next = rad_sum;
        hue_base_next     = hue_stepped;
      end
    end
  end

  // Hold shell state
  always_ff @(posedge clk) begin
    if (rst) begin
      shell_radius <= '0;
      hue_base     <= '0;
    end else begin
      shell_radius <= shell_radius_next;
      hue_base     <= hue_base_next;
    end
  end

  // Queue queries with a snapshot of the shell state they see
  always_comb begin
    push_out.push          = accept && req_type == REQ_QUERY;
    push_out.item.sq_sum   = sq_sum;
    push_out.item.radius   = shell_radius;
    push_out.item.hue_base = hue_base;
  end

endmodule

// ----- hdl/esvs_queue.sv -----
// Short query queue between the front end and the shading pipeline.
module esvs_queue
  import esvs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  push_t push_in,
  output logic  full,
  input  logic  pop,
  output head_t head
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  query_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_pop;

  assign full       = count == CNT_W'(QUEUE_DEPTH);
  assign head.valid = count != '0;
  assign head.item  = slots[rd_ptr];
  assign do_pop     = pop && head.valid;

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push_in.push && !full) begin
      slots[wr_ptr] <= push_in.item;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_in.push && !full) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push_in.push && !full) - CNT_W'(do_pop);
    end
  end

endmodule

// ----- hdl/esvs_back.sv -----
// Shading pipeline: pipelined square root, shell test, hue and HSV color.
module esvs_back
  import esvs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  head_t              head,
  output logic               pop,
  input  cfg_t               cfg,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COLOR_W-1:0] red,
  output logic [COLOR_W-1:0] green,
  output logic [COLOR_W-1:0] blue,
  output logic               lit
);

  localparam int STAGES = ROOT_W;
  localparam logic [HUE_W+1:0] HUE_TWICE = (HUE_W+2)'(2 * HUE_FULL);
  localparam logic [HUE_W+1:0] HUE_ONCE  = (HUE_W+2)'(HUE_FULL);

  logic en;

  // Square root stages
  logic [ROOT_W-1:0] rt      [STAGES];
  logic [REM_W-1:0]  rm      [STAGES];
  query_t            it      [STAGES];
  logic              vl      [STAGES];
  logic [ROOT_W-1:0] rt_next [STAGES];
  logic [REM_W-1:0]  rm_next [STAGES];
  logic [ROOT_W-1:0] src_rt  [STAGES];
  logic [REM_W-1:0]  src_rm  [STAGES];
  query_t            src_it  [STAGES];
  logic              src_vl  [STAGES];

  // Rounded distance stage
  logic [ROOT_W-1:0]   dist_q8;
  query_t              dist_it;
  logic                dist_vl;

  // Shell test and hue stage
  logic                sh_vl;
  logic                sh_lit;
  logic [HUE_W-1:0]    sh_hue;
  logic [RADIUS_W-1:0] diff;
  logic [HTERM_W-1:0]  hprod;
  logic [HUE_W+1:0]    hsum;
  logic [HUE_W-1:0]    hue_mod;

  // Color stage
  logic [2:0]          region;
  logic [HM_W-1:0]     hm;
  logic [COLOR_W-1:0]  cq, ct;
  logic [COLOR_W-1:0]  hr, hg, hb;
  logic                ovr;

  assign en  = !out_valid || out_ready;
  assign pop = en;

  // Feed each root stage from the one before it
  always_comb begin
    src_rt[0] = '0;
    src_rm[0] = '0;
    src_it[0] = head.item;
    src_vl[0] = head.valid;
    for (int k = 1; k < STAGES; k++) begin
      src_rt[k] = rt[k-1];
      src_rm[k] = rm[k-1];
      src_it[k] = it[k-1];
      src_vl[k] = vl[k-1];
    end
  end

  // One result bit per stage
  always_comb begin
    logic [RAD_N_W-1:0] nword;
    logic [REM_W-1:0]   rem_sh;
    logic [REM_W-1:0]   trial;
    for (int k = 0; k < STAGES; k++) begin
      nword  = {src_it[k].sq_sum, {FRAC_W{1'b0}}};
      rem_sh = {src_rm[k][REM_W-3:0], nword[RAD_N_W-1-2*k -: 2]};
      trial  = {{(REM_W-ROOT_W-2){1'b0}}, src_rt[k], 2'b01};
      if (rem_sh >= trial) begin
        rm_next[k] = rem_sh - trial;
        rt_next[k] = {src_rt[k][ROOT_W-2:0], 1'b1};
      end else begin
        rm_next[k] = rem_sh;
        rt_next[k] = {src_rt[k][ROOT_W-2:0], 1'b0};
      end
    end
  end

  // Shell test and hue offset
  always_comb begin
    diff    = (dist_q8 >= dist_it.radius) ? dist_q8 - dist_it.radius
                                          : dist_it.radius - dist_q8;
    hprod   = HTERM_W'(dist_q8) * HTERM_W'(HUE_SPAN);
    hsum    = (HUE_W+2)'(dist_it.hue_base) + (HUE_W+2)'(hprod[HTERM_W-1:8]);
    if (hsum >= HUE_TWICE) begin
      hue_mod = HUE_W'(hsum - HUE_TWICE);
    end else if (hsum >= HUE_ONCE) begin
      hue_mod = HUE_W'(hsum - HUE_ONCE);
    end else begin
      hue_mod = HUE_W'(hsum);
    end
  end

  // Hue sector and position inside it
  always_comb begin
    if (sh_hue >= HUE_W'(5 * HUE_SECTOR)) begin
      region = 3'd5;
      hm     = HM_W'(sh_hue - HUE_W'(5 * HUE_SECTOR));
    end else if (sh_hue >= HUE_W'(4 * HUE_SECTOR)) begin
      region = 3'd4;
      hm     = HM_W'(sh_hue - HUE_W'(4 * HUE_SECTOR));
    end else if (sh_hue >= HUE_W'(3 * HUE_SECTOR)) begin
      region = 3'd3;
      hm     = HM_W'(sh_hue - HUE_W'(3 * HUE_SECTOR));
    end else if (sh_hue >= HUE_W'(2 * HUE_SECTOR)) begin
      region = 3'd2;
      hm     = HM_W'(sh_hue - HUE_W'(2 * HUE_SECTOR));
    end else if (sh_hue >= HUE_W'(HUE_SECTOR)) begin
      region = 3'd1;
      hm     = HM_W'(sh_hue - HUE_W'(HUE_SECTOR));
    end else begin
      region = 3'd0;
      hm     = HM_W'(sh_hue);
    end
    cq = Q_TAB[hm];
    ct = T_TAB[hm];
    case (region)
      3'd0:    begin hr = HSV_V; hg = ct;    hb = HSV_P; end
      3'd1:    begin hr = cq;    hg = HSV_V; hb = HSV_P; end
      3'd2:    begin hr = HSV_P; hg = HSV_V; hb = ct;    end
      3'd3:    begin hr = HSV_P; hg = cq;    hb = HSV_V; end
      3'd4:    begin hr = ct;    hg = HSV_P; hb = HSV_V; end
      default: begin hr = HSV_V; hg = HSV_P; hb = cq;    end
    endcase
    ovr = (cfg.override_red | cfg.override_green | cfg.override_blue) != '0;
  end

  // Advance payload through the pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < STAGES; k++) begin
        rt[k] <= rt_next[k];
        rm[k] <= rm_next[k];
        it[k] <= src_it[k];
      end
      dist_q8 <= rt[STAGES-1] + ROOT_W'(rm[STAGES-1] > REM_W'(rt[STAGES-1]));
      dist_it <= it[STAGES-1];
      sh_lit  <= diff <= RADIUS_W'(cfg.shell_thickness);
      sh_hue  <= hue_mod;
      lit     <= sh_lit;
      if (!sh_lit) begin
        red   <= '0;
        green <= '0;
        blue  <= '0;
      end else if (ovr) begin
        red   <= cfg.override_red;
        green <= cfg.override_green;
        blue  <= cfg.override_blue;
      end else begin
        red   <= hr;
        green <= hg;
        blue  <= hb;
      end
    end
  end

  // Advance valid bits; hold everything while the output word waits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < STAGES; k++) begin
        vl[k] <= 1'b0;
      end
      dist_vl   <= 1'b0;
      sh_vl     <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < STAGES; k++) begin
        vl[k] <= src_vl[k];
      end
      dist_vl   <= vl[STAGES-1];
      sh_vl     <= dist_vl;
      out_valid <= sh_vl;
    end
  end

endmodule
